// ----- hdl/lzd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared constants, types and control structs of the LZSS window decoder.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int WINDOW_SIZE      = 32768;
  localparam int PTR_W            = $clog2(WINDOW_SIZE);
  localparam int BYTES_PER_RESULT = 4;
  localparam int PK_W             = $clog2(BYTES_PER_RESULT);
  localparam int CNT_W            = 3;
  localparam int BYTE_W           = 8;
  localparam int DIST_W           = 15;
  localparam int DIST_HI_W        = 7;
  localparam int LEN_W            = 8;
  localparam int FLAGS_W          = 4;

  localparam logic [FLAGS_W-1:0] TOKENS_PER_FLAG = 4'd8;

  typedef enum logic [1:0] {
    PH_TOKEN,
    PH_DIST_LO,
    PH_LENGTH
  } phase_e;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_e;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } hist_wr_t;

  typedef struct packed {
    logic             re;
    logic [PTR_W-1:0] addr;
  } hist_rd_t;

  typedef struct packed {
    logic              push;
    logic [BYTE_W-1:0] data;
    logic              item_end;
  } pk_ctrl_t;

endpackage

// ----- hdl/lzd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_in_if / lzd_out_if
// Valid/ready channels for compressed input bytes and decoded result words.
// ----------------------------------------------------------------------------
interface lzd_in_if;
  import lzd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzd_out_if;
  import lzd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte0;
  logic [BYTE_W-1:0] out_byte1;
  logic [BYTE_W-1:0] out_byte2;
  logic [BYTE_W-1:0] out_byte3;
  logic [CNT_W-1:0]  byte_count;
  logic              last;

  modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                  output out_byte3, output byte_count, output last, input ready);
  modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                  input out_byte3, input byte_count, input last, output ready);
endinterface

// ----- hdl/lzss_window_decoder.sv -----
`timescale 1ns / 1ps
// Flag, distance, length-zero and literal bytes are each accepted directly; a literal's
// word is on the output the cycle after. A match of length L is copied one byte per cycle
// while the output register is free, through the single read port of the history RAM,
// ready low meanwhile.
// Input is taken only when the output register is empty or being emptied.
// Reset clears all control state; history entries read as zero until written
// (fill count, no clearing pass, ready from the first cycle after reset).
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS decoder with a 32 KiB history ring: token parser and copy sequencer.
// ----------------------------------------------------------------------------
module lzss_window_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  lzd_in_if.sink     in_i,
  lzd_out_if.source  out_o
);
  import lzd_pkg::*;

  state_e             state_q, state_d;
  phase_e             phase_q, phase_d;
  logic [BYTE_W-1:0]  flag_bits_q, flag_bits_d;
  logic [FLAGS_W-1:0] flags_left_q, flags_left_d;
  logic [DIST_HI_W-1:0] dist_hi_q, dist_hi_d;
  logic [BYTE_W-1:0]  dist_lo_q, dist_lo_d;
  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [LEN_W-1:0]   iss_left_q, iss_left_d;
  logic [LEN_W-1:0]   wr_left_q, wr_left_d;
  logic               pend_q, pend_d;

  logic [DIST_W-1:0]  match_dist;
  logic [BYTE_W-1:0]  hist_data;
  logic               out_free;
  logic               in_rdy;
  logic               in_acc;
  logic               advance;
  logic               issue;
  hist_wr_t           hist_wr;
  hist_rd_t           hist_rd;
  pk_ctrl_t           pk_ctl;

  assign match_dist = {dist_hi_q, dist_lo_q};
  assign in_rdy     = (state_q == ST_IDLE) && out_free;
  assign in_i.ready = in_rdy;
  assign in_acc     = in_i.valid && in_rdy;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    flag_bits_d  = flag_bits_q;
    flags_left_d = flags_left_q;
    dist_hi_d    = dist_hi_q;
    dist_lo_d    = dist_lo_q;
    wp_d         = wp_q;
    rd_ptr_d     = rd_ptr_q;
    iss_left_d   = iss_left_q;
    wr_left_d    = wr_left_q;
    pend_d       = pend_q;
    hist_wr      = '0;
    hist_rd      = '0;
    pk_ctl       = '0;
    advance      = 1'b0;
    issue        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (phase_q)
            PH_DIST_LO: begin
              dist_lo_d = in_i.in_byte;
              phase_d   = PH_LENGTH;
            end
            PH_LENGTH: begin
              phase_d = PH_TOKEN;
              if (in_i.in_byte != '0) begin
                state_d    = ST_COPY;
                rd_ptr_d   = wp_q - match_dist[PTR_W-1:0];
                iss_left_d = in_i.in_byte;
                wr_left_d  = in_i.in_byte;
                pend_d     = 1'b0;
              end
            end
            default: begin
              if (flags_left_q == '0) begin
                flag_bits_d  = in_i.in_byte;
                flags_left_d = TOKENS_PER_FLAG;
              end else begin
                flag_bits_d  = {flag_bits_q[BYTE_W-2:0], 1'b0};
                flags_left_d = flags_left_q - FLAGS_W'(1);
                if (flag_bits_q[BYTE_W-1]) begin
                  dist_hi_d = in_i.in_byte[DIST_HI_W-1:0];
                  phase_d   = PH_DIST_LO;
                end else begin
                  hist_wr.we      = 1'b1;
                  hist_wr.addr    = wp_q;
                  hist_wr.data    = in_i.in_byte;
                  wp_d            = wp_q + PTR_W'(1);
                  pk_ctl.push     = 1'b1;
                  pk_ctl.data     = in_i.in_byte;
                  pk_ctl.item_end = 1'b1;
                end
              end
            end
          endcase
        end
      end
      ST_COPY: begin
        // one read in flight; the pending read byte is written back and packed once the output is free
        advance = pend_q && out_free;
        issue   = (iss_left_q != '0) && (!pend_q || advance);
        if (advance) begin
          hist_wr.we      = 1'b1;
          hist_wr.addr    = wp_q;
          hist_wr.data    = hist_data;
          wp_d            = wp_q + PTR_W'(1);
          wr_left_d       = wr_left_q - LEN_W'(1);
          pk_ctl.push     = 1'b1;
          pk_ctl.data     = hist_data;
          pk_ctl.item_end = (wr_left_q == LEN_W'(1));
          pend_d          = 1'b0;
          if (wr_left_q == LEN_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
        if (issue) begin
          hist_rd.re   = 1'b1;
          hist_rd.addr = rd_ptr_q;
          rd_ptr_d     = rd_ptr_q + PTR_W'(1);
          iss_left_d   = iss_left_q - LEN_W'(1);
          pend_d       = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TOKEN;
      flag_bits_q  <= '0;
      flags_left_q <= '0;
      dist_hi_q    <= '0;
      dist_lo_q    <= '0;
      wp_q         <= '0;
      rd_ptr_q     <= '0;
      iss_left_q   <= '0;
      wr_left_q    <= '0;
      pend_q       <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      flag_bits_q  <= flag_bits_d;
      flags_left_q <= flags_left_d;
      dist_hi_q    <= dist_hi_d;
      dist_lo_q    <= dist_lo_d;
      wp_q         <= wp_d;
      rd_ptr_q     <= rd_ptr_d;
      iss_left_q   <= iss_left_d;
      wr_left_q    <= wr_left_d;
      pend_q       <= pend_d;
    end
  end

  lzd_history u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (hist_wr),
    .rd_i      (hist_rd),
    .rd_data_o (hist_data)
  );

  lzd_packer u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (pk_ctl),
    .out_free_o (out_free),
    .out_o      (out_o)
  );

endmodule

// ----- hdl/lzd_history.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_history
// History ring RAM: one write port, one registered read port. Entries never
// written read as zero, tracked by a fill count since writes are sequential.
// ----------------------------------------------------------------------------
module lzd_history (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lzd_pkg::hist_wr_t        wr_i,
  input  lzd_pkg::hist_rd_t        rd_i,
  output logic [lzd_pkg::BYTE_W-1:0] rd_data_o
);
  import lzd_pkg::*;

  logic [BYTE_W-1:0] mem [WINDOW_SIZE];
  logic [BYTE_W-1:0] rdata_q;
  logic [BYTE_W-1:0] fwd_data_q;
  logic [PTR_W-1:0]  fill_q;
  logic              full_q;
  logic              vld_q;
  logic              fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.re) begin
      rdata_q    <= mem[rd_i.addr];
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      full_q <= 1'b0;
      vld_q  <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      if (wr_i.we && !full_q) begin
        fill_q <= fill_q + PTR_W'(1);
        if (fill_q == '1) begin
          full_q <= 1'b1;
        end
      end
      if (rd_i.re) begin
        vld_q <= full_q || (rd_i.addr < fill_q);
        // read of the slot being written this cycle: take the new byte
        fwd_q <= wr_i.we && (wr_i.addr == rd_i.addr);
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : (vld_q ? rdata_q : '0);

endmodule

// ----- hdl/lzd_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_packer
// Gathers decoded bytes into result words of up to four bytes and holds
// the finished word in the output register until it is taken.
// ----------------------------------------------------------------------------
module lzd_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzd_pkg::pk_ctrl_t   ctl_i,
  output logic                out_free_o,
  lzd_out_if.source           out_o
);
  import lzd_pkg::*;

  logic [BYTE_W-1:0] pk_q [BYTES_PER_RESULT];
  logic [BYTE_W-1:0] ob_q [BYTES_PER_RESULT];
  logic [BYTE_W-1:0] ob_d [BYTES_PER_RESULT];
  logic [PK_W-1:0]   cnt_q;
  logic [PK_W-1:0]   cnt_d;
  logic [CNT_W-1:0]  count_q;
  logic              last_q;
  logic              valid_q;
  logic              valid_d;
  logic              load;

  assign out_free_o = !valid_q || out_o.ready;
  assign load       = ctl_i.push && (ctl_i.item_end || (cnt_q == PK_W'(BYTES_PER_RESULT - 1)));

  always_comb begin
    for (int i = 0; i < BYTES_PER_RESULT; i++) begin
      if (PK_W'(i) < cnt_q) begin
        ob_d[i] = pk_q[i];
      end else if (PK_W'(i) == cnt_q) begin
        ob_d[i] = ctl_i.data;
      end else begin
        ob_d[i] = '0;
      end
    end
    cnt_d = cnt_q;
    if (ctl_i.push) begin
      cnt_d = load ? '0 : cnt_q + PK_W'(1);
    end
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && !load) begin
      pk_q[cnt_q] <= ctl_i.data;
    end
    if (load) begin
      ob_q    <= ob_d;
      count_q <= CNT_W'(cnt_q) + CNT_W'(1);
      last_q  <= ctl_i.item_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte0  = ob_q[0];
  assign out_o.out_byte1  = ob_q[1];
  assign out_o.out_byte2  = ob_q[2];
  assign out_o.out_byte3  = ob_q[3];
  assign out_o.byte_count = count_q;
  assign out_o.last       = last_q;

endmodule

// ----- hdl/lzd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_checker
// Port-level checks of the decoder's result words and input flow control.
// ----------------------------------------------------------------------------
module lzd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte1_i,
  input logic [7:0] out_byte2_i,
  input logic [7:0] out_byte3_i,
  input logic [2:0] byte_count_i,
  input logic       last_i
);

  // word carries one to four bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (byte_count_i != 3'd0) && (byte_count_i <= 3'd4))
    else $error("byte_count out of range");

  // slots past the count are zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((byte_count_i > 3'd1) || (out_byte1_i == 8'd0)) &&
                    ((byte_count_i > 3'd2) || (out_byte2_i == 8'd0)) &&
                    ((byte_count_i > 3'd3) || (out_byte3_i == 8'd0)))
    else $error("unused byte slot not zero");

  // no input taken while a word waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input ready while output stalled");

  // mid-copy words keep the input side closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_i) |-> !(in_valid_i && in_ready_i))
    else $error("input accepted inside a copy");

  // stalled word stays valid with its count and last flag held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(byte_count_i) && $stable(last_i))
    else $error("stalled word changed");

endmodule

bind lzss_window_decoder lzd_checker u_lzd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte1_i  (out_o.out_byte1),
  .out_byte2_i  (out_o.out_byte2),
  .out_byte3_i  (out_o.out_byte3),
  .byte_count_i (out_o.byte_count),
  .last_i       (out_o.last)
);
